// ===== hw/rtl/cau_pkg.sv =====
// Shared types, codes and saturation helpers for the complex arithmetic unit.
`timescale 1ns / 1ps
package cau_pkg;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_NEG = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  // quotient bits 32..0; the remainder holds the shifted dividend and D << 33
  localparam int QB = 33;
  localparam int DW = 98;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] a_real;
    logic signed [31:0] a_imag;
    logic signed [31:0] b_real;
    logic signed [31:0] b_imag;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] result_real;
    logic signed [31:0] result_imag;
    logic [1:0]         status;
  } res_t;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QB-1:0] quo;
    logic          neg;
    logic          big;
  } div_lane_t;

  typedef struct packed {
    logic      valid;
    logic      is_div;
    res_t      early;
    logic [63:0] d;
    div_lane_t lane_r;
    div_lane_t lane_i;
  } div_pipe_t;

  // {overflow, saturated value}
  function automatic logic [32:0] sat_s33(input logic signed [32:0] v);
    logic [32:0] r;
    if (v > 33'sh07FFFFFFF) r = {1'b1, S32_MAX};
    else if (v < -33'sh080000000) r = {1'b1, S32_MIN};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

  function automatic logic [32:0] sat_s65(input logic signed [64:0] v);
    logic [32:0] r;
    if (v > 65'sh07FFFFFFF) r = {1'b1, S32_MAX};
    else if (v < -65'sh080000000) r = {1'b1, S32_MIN};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

endpackage

// ===== hw/rtl/complex_arith_unit_core.sv =====
// Top level of the pipelined complex arithmetic unit.
`timescale 1ns / 1ps
// Complex ALU on signed fixed-point operands. A command beat is taken in any
// cycle (busy stays low) and its result appears with done at the end of the
// pipeline, one result per cycle at full rate. The divider forms the longest
// part: 33 registered restoring steps, one quotient bit each, behind four
// front stages (capture, products, sums, overflow precheck) and one output
// stage. All opcodes pass through the same stages, so results leave in order.
// The receiver cannot stall; a result is valid only in its done cycle.
module complex_arith_unit_core import cau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output logic done,
  output res_t result
);

  localparam int LAT = QB + 5;

  div_pipe_t pipe [0:QB];

  assign busy = 1'b0;

  cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .cmd      (cmd),
    .pipe_out (pipe[0])
  );

  for (genvar g = 0; g < QB; g++) begin : g_div
    cau_div_step #(.STEP(QB - 1 - g)) u_step (
      .clk      (clk),
      .rst      (rst),
      .pipe_in  (pipe[g]),
      .pipe_out (pipe[g+1])
    );
  end

  cau_back u_back (
    .clk     (clk),
    .rst     (rst),
    .pipe_in (pipe[QB]),
    .done    (done),
    .result  (result)
  );

  a_lat: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("accepted beat did not complete on time");

  a_div0: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.opcode == OP_DIV && cmd.b_real == 32'sd0 &&
    cmd.b_imag == 32'sd0 |-> ##LAT (done && result.status == ST_DIV0))
    else $error("zero divisor not flagged");

  a_unused: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (cmd.opcode > OP_NEG)
    |-> ##LAT (done && result == '0))
    else $error("unused opcode gave nonzero result");

  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> result.status <= ST_DIV0)
    else $error("illegal status code");

endmodule

// ===== hw/rtl/cau_front.sv =====
// Front pipeline: operand capture, products, sums and divider setup.
`timescale 1ns / 1ps
module cau_front import cau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  cmd_t      cmd,
  output div_pipe_t pipe_out
);

  // stage 1
  logic v1;
  cmd_t c1;

  // stage 2
  logic               v2;
  logic [2:0]         op2;
  logic signed [63:0] prr, pii, pri, pir;
  logic [63:0]        sqr, sqi;
  res_t               easy2;
  logic               div0_2;

  // stage 3
  logic        v3;
  logic        is_div3;
  res_t        early3;
  logic [63:0] d3;
  logic [63:0] magr3, magi3;
  logic        negr3, negi3;

  res_t              easy_c;
  logic [32:0]       sr, si;
  logic              div0_c;
  logic signed [64:0] mul_r, mul_i, num_r, num_i;
  logic [32:0]       mr, mi;
  res_t              early_c;
  logic [DW-1:0]     nr_w, ni_w, dlim;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= in_valid;
    c1 <= cmd;
  end

  assign div0_c = (c1.b_real == 32'sd0) && (c1.b_imag == 32'sd0);

  always_comb begin
    easy_c = '0;
    sr = '0;
    si = '0;
    unique case (c1.opcode)
      OP_ADD: begin
        sr = sat_s33(33'(c1.a_real) + 33'(c1.b_real));
        si = sat_s33(33'(c1.a_imag) + 33'(c1.b_imag));
      end
      OP_SUB: begin
        sr = sat_s33(33'(c1.a_real) - 33'(c1.b_real));
        si = sat_s33(33'(c1.a_imag) - 33'(c1.b_imag));
      end
      OP_NEG: begin
        sr = sat_s33(-33'(c1.a_real));
        si = sat_s33(-33'(c1.a_imag));
      end
      default: ;
    endcase
    easy_c.result_real = sr[31:0];
    easy_c.result_imag = si[31:0];
    easy_c.status      = (sr[32] || si[32]) ? ST_OVF : ST_OK;
    if (c1.opcode == OP_DIV && div0_c) begin
      easy_c.result_real = c1.a_real[31] ? S32_MIN : S32_MAX;
      easy_c.result_imag = c1.a_imag[31] ? S32_MIN : S32_MAX;
      easy_c.status      = ST_DIV0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    op2    <= c1.opcode;
    prr    <= c1.a_real * c1.b_real;
    pii    <= c1.a_imag * c1.b_imag;
    pri    <= c1.a_real * c1.b_imag;
    pir    <= c1.a_imag * c1.b_real;
    sqr    <= 64'(c1.b_real) * 64'(c1.b_real);
    sqi    <= 64'(c1.b_imag) * 64'(c1.b_imag);
    easy2  <= easy_c;
    div0_2 <= div0_c;
  end

  always_comb begin
    mul_r = (65'(prr) - 65'(pii)) >>> FRAC_BITS;
    mul_i = (65'(pri) + 65'(pir)) >>> FRAC_BITS;
    mr    = sat_s65(mul_r);
    mi    = sat_s65(mul_i);
    num_r = 65'(prr) + 65'(pii);
    num_i = 65'(pir) - 65'(pri);
    early_c = easy2;
    if (op2 == OP_MUL) begin
      early_c.result_real = mr[31:0];
      early_c.result_imag = mi[31:0];
      early_c.status      = (mr[32] || mi[32]) ? ST_OVF : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    is_div3 <= (op2 == OP_DIV) && !div0_2;
    early3  <= early_c;
    d3      <= sqr + sqi;
    negr3   <= num_r[64];
    negi3   <= num_i[64];
    magr3   <= num_r[64] ? 64'(-num_r) : num_r[63:0];
    magi3   <= num_i[64] ? 64'(-num_i) : num_i[63:0];
  end

  // dividend = magnitude << FRAC_BITS; quotient of 2^33 or more saturates
  assign nr_w = DW'({magr3, {FRAC_BITS{1'b0}}});
  assign ni_w = DW'({magi3, {FRAC_BITS{1'b0}}});
  assign dlim = DW'(d3) << QB;

  always_ff @(posedge clk) begin
    if (rst) pipe_out.valid <= 1'b0;
    else pipe_out.valid <= v3;
    pipe_out.is_div     <= is_div3;
    pipe_out.early      <= early3;
    pipe_out.d          <= d3;
    pipe_out.lane_r.rem <= nr_w;
    pipe_out.lane_r.quo <= '0;
    pipe_out.lane_r.neg <= negr3;
    pipe_out.lane_r.big <= nr_w >= dlim;
    pipe_out.lane_i.rem <= ni_w;
    pipe_out.lane_i.quo <= '0;
    pipe_out.lane_i.neg <= negi3;
    pipe_out.lane_i.big <= ni_w >= dlim;
  end

endmodule

// ===== hw/rtl/cau_div_step.sv =====
// One registered restoring-division step, both result parts side by side.
`timescale 1ns / 1ps
module cau_div_step import cau_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  div_pipe_t pipe_in,
  output div_pipe_t pipe_out
);

  logic [DW-1:0] dsh;
  div_lane_t     r_next, i_next;

  assign dsh = DW'(pipe_in.d) << STEP;

  always_comb begin
    r_next = pipe_in.lane_r;
    i_next = pipe_in.lane_i;
    if (pipe_in.lane_r.rem >= dsh) begin
      r_next.rem       = pipe_in.lane_r.rem - dsh;
      r_next.quo[STEP] = 1'b1;
    end
    if (pipe_in.lane_i.rem >= dsh) begin
      i_next.rem       = pipe_in.lane_i.rem - dsh;
      i_next.quo[STEP] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) pipe_out.valid <= 1'b0;
    else pipe_out.valid <= pipe_in.valid;
    pipe_out.is_div <= pipe_in.is_div;
    pipe_out.early  <= pipe_in.early;
    pipe_out.d      <= pipe_in.d;
    pipe_out.lane_r <= r_next;
    pipe_out.lane_i <= i_next;
  end

endmodule

// ===== hw/rtl/cau_back.sv =====
// Output stage: quotient sign and saturation, result select.
`timescale 1ns / 1ps
module cau_back import cau_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  div_pipe_t pipe_in,
  output logic      done,
  output res_t      result
);

  logic [32:0] qr, qi;
  res_t        res_next;

  function automatic logic [32:0] fin(input div_lane_t l);
    logic [32:0] r;
    if (l.neg) begin
      if (l.big || l.quo > 33'h080000000) r = {1'b1, S32_MIN};
      else r = {1'b0, ~l.quo[31:0] + 32'd1};
    end else begin
      if (l.big || l.quo > 33'h07FFFFFFF) r = {1'b1, S32_MAX};
      else r = {1'b0, l.quo[31:0]};
    end
    return r;
  endfunction

  always_comb begin
    qr = fin(pipe_in.lane_r);
    qi = fin(pipe_in.lane_i);
    res_next = pipe_in.early;
    if (pipe_in.is_div) begin
      res_next.result_real = qr[31:0];
      res_next.result_imag = qi[31:0];
      res_next.status      = (qr[32] || qi[32]) ? ST_OVF : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= pipe_in.valid;
    result <= res_next;
  end

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the complex arithmetic unit core.
`timescale 1ns / 1ps
module tb_top;
  import cau_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = 38;
  localparam int STALL_LIMIT = 4000;
  localparam int N_RANDOM = 1880;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd = '0;
  logic done;
  res_t result;

  res_t expected_q[$];
  int   n_errors = 0;
  int   n_sent = 0;
  int   n_checked = 0;
  int   n_div0 = 0;
  int   n_sat = 0;
  int   idle_pct = 0;
  int   quiet_cycles = 0;

  always #5 clk = ~clk;

  complex_arith_unit_core #(.FRAC_BITS(FRAC)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .done(done), .result(result)
  );

  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
                                                 inout logic ovf);
    if (v > 128'sd2147483647) begin
      ovf = 1'b1;
      return S32_MAX;
    end
    if (v < -128'sd2147483648) begin
      ovf = 1'b1;
      return S32_MIN;
    end
    return v[31:0];
  endfunction

  // numerator * 2^FRAC / den, truncated toward zero
  function automatic logic signed [31:0] div_part(input logic signed [127:0] num,
                                                  input logic signed [127:0] den,
                                                  inout logic ovf);
    logic signed [127:0] mag;
    logic signed [127:0] quo;
    mag = (num < 0) ? -num : num;
    quo = (mag <<< FRAC) / den;
    return clamp32((num < 0) ? -quo : quo, ovf);
  endfunction

  function automatic res_t predict_result(input cmd_t c);
    logic signed [127:0] ar, ai, br, bi, den;
    logic ovf;
    res_t r;
    ar = c.a_real;
    ai = c.a_imag;
    br = c.b_real;
    bi = c.b_imag;
    ovf = 1'b0;
    r = '0;
    r.status = ST_OK;
    case (c.opcode)
      OP_ADD: begin
        r.result_real = clamp32(ar + br, ovf);
        r.result_imag = clamp32(ai + bi, ovf);
      end
      OP_SUB: begin
        r.result_real = clamp32(ar - br, ovf);
        r.result_imag = clamp32(ai - bi, ovf);
      end
      OP_MUL: begin
        r.result_real = clamp32((ar * br - ai * bi) >>> FRAC, ovf);
        r.result_imag = clamp32((ar * bi + ai * br) >>> FRAC, ovf);
      end
      OP_DIV: begin
        if (br == 0 && bi == 0) begin
          r.result_real = (ar >= 0) ? S32_MAX : S32_MIN;
          r.result_imag = (ai >= 0) ? S32_MAX : S32_MIN;
          r.status = ST_DIV0;
        end else begin
          den = br * br + bi * bi;
          r.result_real = div_part(ar * br + ai * bi, den, ovf);
          r.result_imag = div_part(ai * br - ar * bi, den, ovf);
        end
      end
      OP_NEG: begin
        r.result_real = clamp32(-ar, ovf);
        r.result_imag = clamp32(-ai, ovf);
      end
      default: ;
    endcase
    if (r.status == ST_OK && ovf) r.status = ST_OVF;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH result %0d %s: got %h expected %h", n_checked, what, got, want);
    n_errors++;
  endtask

  // result checker: one beat per done cycle, oldest expectation first
  always @(posedge clk) begin
    res_t want;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", result.result_real, 32'h0);
      end else begin
        want = expected_q.pop_front();
        if (result.result_real !== want.result_real)
          report_mismatch("result_real", result.result_real, want.result_real);
        if (result.result_imag !== want.result_imag)
          report_mismatch("result_imag", result.result_imag, want.result_imag);
        if (result.status !== want.status)
          report_mismatch("status", {30'b0, result.status}, {30'b0, want.status});
      end
      n_checked++;
    end
  end

  // watchdog on cycles with no beat in either direction
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no progress for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // each cycle is idle with probability idle_pct before the beat goes out
  task automatic send_cmd(input cmd_t c);
    res_t want;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    cmd <= c;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    want = predict_result(c);
    expected_q.push_back(want);
    n_sent++;
    if (want.status == ST_DIV0) n_div0++;
    if (want.status == ST_OVF) n_sat++;
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      4: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_t make_cmd(input logic [2:0] op, input logic [31:0] ar,
                                    input logic [31:0] ai, input logic [31:0] br,
                                    input logic [31:0] bi);
    cmd_t c;
    c.opcode = op;
    c.a_real = ar;
    c.a_imag = ai;
    c.b_real = br;
    c.b_imag = bi;
    return c;
  endfunction

  task automatic test_directed();
    logic [31:0] one;
    logic [2:0] op;
    one = 32'h0001_0000;
    idle_pct = 0;
    for (int k = 0; k < 5; k++) begin
      op = 3'(k);
      send_cmd(make_cmd(op, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    end
    send_cmd(make_cmd(OP_ADD, 32'h0003_0000, -32'sh0002_0000, one, 32'h0));
    send_cmd(make_cmd(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, one, -32'sh1));
    send_cmd(make_cmd(OP_MUL, one, one, one, -32'sh0001_0000));
    send_cmd(make_cmd(OP_MUL, -32'sh1, 32'h1, 32'h1, 32'h1));
    send_cmd(make_cmd(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    send_cmd(make_cmd(OP_DIV, one, -32'sh0001_0000, 32'h0, 32'h0));
    send_cmd(make_cmd(OP_DIV, 32'h0, 32'h8000_0000, 32'h0, 32'h0));
    send_cmd(make_cmd(OP_DIV, 32'h0003_0000, 32'h0001_0000, 32'h0, one));
    send_cmd(make_cmd(OP_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1, 32'h0));
    send_cmd(make_cmd(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_cmd(make_cmd(OP_DIV, -32'sh7, 32'h5, 32'h0002_0000, 32'h0));
    send_cmd(make_cmd(OP_NEG, 32'h8000_0000, 32'h0, 32'h1234, 32'h5678));
    send_cmd(make_cmd(OP_NEG, 32'h7FFF_FFFF, -32'sh1, 32'h0, 32'h0));
    // unused opcodes return zero
    for (int k = 5; k < 8; k++) begin
      op = 3'(k);
      send_cmd(make_cmd(op, $urandom, $urandom, $urandom, $urandom));
    end
    start <= 1'b0;
  endtask

  task automatic test_random(input int pct, input int count);
    cmd_t c;
    idle_pct = pct;
    for (int n = 0; n < count; n++) begin
      c = make_cmd($urandom_range(0, 19) == 0 ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4)),
                   rand_operand(), rand_operand(), rand_operand(), rand_operand());
      // scalar forms and zero divisors
      case ($urandom_range(0, 9))
        0: c.b_imag = '0;
        1: c.a_imag = '0;
        2: if (c.opcode == OP_DIV) begin
          c.b_real = '0;
          c.b_imag = '0;
        end
        default: ;
      endcase
      send_cmd(c);
    end
    start <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(0, N_RANDOM / 4);
    test_random(70, N_RANDOM / 4);
    test_random(18, N_RANDOM / 4);
    test_random(0, N_RANDOM / 4);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Ran %0d commands over all opcodes, %0d results checked", n_sent, n_checked);
    $display("  %0d saturated, %0d zero-divisor cases, sender idle phases 0/70/18%%",
             n_sat, n_div0);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/cau_pkg.sv
hw/rtl/cau_front.sv
hw/rtl/cau_div_step.sv
hw/rtl/cau_back.sv
hw/rtl/complex_arith_unit_core.sv
sim/tb_top.sv
